@@ rtl/core/vecrot_pkg.sv @@
// ----------------------------------------------------------------------------
// vecrot_pkg
// Shared widths, item types and the arctangent table for the axis-angle
// vector rotation pipeline.
// ----------------------------------------------------------------------------
package vecrot_pkg;

   // component and angle formats
   localparam int COMP_W    = 32;
   localparam int ANGLE_W   = 16;
   localparam int TURN_W    = 32;
   // fraction bits of the unit axis and of cos / sin
   localparam int UNIT_BITS = 30;
   localparam int TRIG_BITS = 27;
   // cordic rotator
   localparam int TRIG_ITER = 16;
   localparam int TRIG_W    = 32;
   localparam int Z_W       = 33;
   localparam logic [TURN_W-1:0] CORDIC_GAIN = 32'h9B74EDA8;
   // normalised axis, square root and divider
   localparam int NORM_W     = UNIT_BITS + 1;
   localparam int MAG_W      = COMP_W + 1;
   localparam int BITS_W     = 6;
   localparam int WIDE_W     = 64;
   localparam int LEN_W      = 32;
   localparam int SQRT_STEPS = 32;
   localparam int QUO_W      = 32;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [NORM_W-1:0] norm_type;
   typedef logic signed [TRIG_W-1:0] trig_type;

   // item as accepted on the request side
   typedef struct packed {
      comp_type [2:0]     vec;
      comp_type [2:0]     axis;
      logic [ANGLE_W-1:0] angle;
   } item_type;

   // item after the rotator
   typedef struct packed {
      comp_type [2:0] vec;
      comp_type [2:0] axis;
      trig_type       cs;
      trig_type       sn;
   } trig_item_type;

   // fields that ride along unchanged through root and divider
   typedef struct packed {
      comp_type [2:0] vec;
      trig_type       cs;
      trig_type       sn;
      logic           zero;
   } carry_type;

   // item after axis scaling and sum of squares
   typedef struct packed {
      carry_type          c;
      norm_type [2:0]     an;
      logic [WIDE_W-1:0]  ss;
   } norm_item_type;

   // item after the square root
   typedef struct packed {
      carry_type         c;
      norm_type [2:0]    an;
      logic [LEN_W-1:0]  len;
   } root_item_type;

   // item with the unit axis
   typedef struct packed {
      carry_type      c;
      comp_type [2:0] u;
   } unit_item_type;

   // result item
   typedef struct packed {
      comp_type [2:0] rot;
      logic           success;
   } result_type;

   // arctangent of 2^-idx in units of 2^32 per turn
   function automatic logic [TURN_W-1:0] atan_turn(input int unsigned idx);
      logic [TURN_W-1:0] val;
      case (idx)
         0:  val = 32'h20000000;
         1:  val = 32'h12E4051E;
         2:  val = 32'h09FB385B;
         3:  val = 32'h051111D4;
         4:  val = 32'h028B0D43;
         5:  val = 32'h0145D7E1;
         6:  val = 32'h00A2F61E;
         7:  val = 32'h00517C55;
         8:  val = 32'h0028BE53;
         9:  val = 32'h00145F2F;
         10: val = 32'h000A2F98;
         11: val = 32'h000517CC;
         12: val = 32'h00028BE6;
         13: val = 32'h000145F3;
         14: val = 32'h0000A2FA;
         15: val = 32'h0000517D;
         16: val = 32'h000028BE;
         17: val = 32'h0000145F;
         18: val = 32'h00000A30;
         19: val = 32'h00000518;
         20: val = 32'h0000028C;
         21: val = 32'h00000146;
         22: val = 32'h000000A3;
         23: val = 32'h00000051;
         24: val = 32'h00000029;
         25: val = 32'h00000014;
         26: val = 32'h0000000A;
         27: val = 32'h00000005;
         28: val = 32'h00000003;
         29: val = 32'h00000001;
         30: val = 32'h00000001;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/core/vecrot_cordic.sv @@
// ----------------------------------------------------------------------------
// vecrot_cordic
// Pipelined cordic rotator, one iteration per stage, producing cos and sin
// of the binary angle with the quadrant folded in at the last stage.
// ----------------------------------------------------------------------------
module vecrot_cordic (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  vecrot_pkg::item_type       in_item,
   output logic                       out_valid,
   output vecrot_pkg::trig_item_type  out_item
);
   import vecrot_pkg::*;

   logic [TRIG_ITER+1:0]        valid_ff;
   trig_type                    x_ff    [TRIG_ITER+1];
   trig_type                    y_ff    [TRIG_ITER+1];
   logic signed [Z_W-1:0]       z_ff    [TRIG_ITER+1];
   logic [1:0]                  quad_ff [TRIG_ITER+1];
   comp_type [2:0]              vec_ff  [TRIG_ITER+1];
   comp_type [2:0]              axis_ff [TRIG_ITER+1];
   logic [TURN_W-1:0]           turn_in;
   trig_item_type               out_ff;
   trig_item_type               out_in;

   // valid bits move with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[TRIG_ITER:0], in_valid};
      end
   end

   // load: angle to a turn, start vector on the x axis with the gain folded in
   assign turn_in = TURN_W'(in_item.angle) << (TURN_W - ANGLE_W);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= trig_type'(CORDIC_GAIN >> (TURN_W - TRIG_BITS));
         y_ff[0]    <= '0;
         z_ff[0]    <= Z_W'(turn_in[TURN_W-3:0]);
         quad_ff[0] <= turn_in[TURN_W-1:TURN_W-2];
         vec_ff[0]  <= in_item.vec;
         axis_ff[0] <= in_item.axis;
      end
   end

   // one micro-rotation per stage
   for (genvar k = 0; k < TRIG_ITER; k++) begin : g_iter
      trig_type              dx;
      trig_type              dy;
      logic signed [Z_W-1:0] at;

      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;
      assign at = $signed({1'b0, atan_turn(k)});

      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[k][Z_W-1]) begin
               x_ff[k+1] <= x_ff[k] - dx;
               y_ff[k+1] <= y_ff[k] + dy;
               z_ff[k+1] <= z_ff[k] - at;
            end else begin
               x_ff[k+1] <= x_ff[k] + dx;
               y_ff[k+1] <= y_ff[k] - dy;
               z_ff[k+1] <= z_ff[k] + at;
            end
            quad_ff[k+1] <= quad_ff[k];
            vec_ff[k+1]  <= vec_ff[k];
            axis_ff[k+1] <= axis_ff[k];
         end
      end
   end

   // quadrant fold
   always_comb begin
      out_in.vec  = vec_ff[TRIG_ITER];
      out_in.axis = axis_ff[TRIG_ITER];
      case (quad_ff[TRIG_ITER])
         2'd0: begin
            out_in.cs = x_ff[TRIG_ITER];
            out_in.sn = y_ff[TRIG_ITER];
         end
         2'd1: begin
            out_in.cs = -y_ff[TRIG_ITER];
            out_in.sn = x_ff[TRIG_ITER];
         end
         2'd2: begin
            out_in.cs = -x_ff[TRIG_ITER];
            out_in.sn = -y_ff[TRIG_ITER];
         end
         default: begin
            out_in.cs = y_ff[TRIG_ITER];
            out_in.sn = -x_ff[TRIG_ITER];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff[TRIG_ITER+1];
   assign out_item  = out_ff;

endmodule

@@ rtl/core/vecrot_axis_prep.sv @@
// ----------------------------------------------------------------------------
// vecrot_axis_prep
// Scales the axis so that its largest component has thirty significant bits
// and forms the sum of squares of the scaled components.
// ----------------------------------------------------------------------------
module vecrot_axis_prep (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  vecrot_pkg::trig_item_type  in_item,
   output logic                       out_valid,
   output vecrot_pkg::norm_item_type  out_item
);
   import vecrot_pkg::*;

   logic [4:0]              valid_ff;
   // stage 0: largest magnitude
   trig_item_type           t0_ff;
   logic [MAG_W-1:0]        m_ff;
   logic [MAG_W-1:0]        m_in;
   // stage 1: significant bit count
   trig_item_type           t1_ff;
   logic [BITS_W-1:0]       bits_ff;
   logic [BITS_W-1:0]       bits_in;
   logic                    zero1_ff;
   // stage 2: scaled axis
   carry_type               c2_ff;
   norm_type [2:0]          an2_ff;
   norm_type [2:0]          an2_in;
   // stage 3: squares
   carry_type               c3_ff;
   norm_type [2:0]          an3_ff;
   logic [2*NORM_W-1:0]     sq_ff [3];
   // stage 4: sum
   norm_item_type           out_ff;
   carry_type               c2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // largest axis magnitude
   always_comb begin
      logic [MAG_W-1:0] mag [3];
      for (int i = 0; i < 3; i++) begin
         mag[i] = in_item.axis[i][COMP_W-1] ? MAG_W'(-$signed(MAG_W'($signed(in_item.axis[i]))))
                                            : MAG_W'(in_item.axis[i]);
      end
      m_in = mag[0];
      if (mag[1] > m_in) begin
         m_in = mag[1];
      end
      if (mag[2] > m_in) begin
         m_in = mag[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff <= in_item;
         m_ff  <= m_in;
      end
   end

   // position of the leading one
   always_comb begin
      bits_in = '0;
      for (int k = 0; k < MAG_W; k++) begin
         if (m_ff[k]) begin
            bits_in = BITS_W'(k + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff    <= t0_ff;
         bits_ff  <= bits_in;
         zero1_ff <= (m_ff == '0);
      end
   end

   // floor(a * 2^(30 - bits)) as (a * 2^32) >>> (bits + 2)
   always_comb begin
      logic signed [WIDE_W-1:0] ext;
      logic signed [WIDE_W-1:0] shifted;
      logic [BITS_W-1:0]        sh;
      sh = bits_ff + BITS_W'(2);
      for (int i = 0; i < 3; i++) begin
         ext       = $signed({t1_ff.axis[i], 32'b0});
         shifted   = ext >>> sh;
         an2_in[i] = shifted[NORM_W-1:0];
      end
      c2_in.vec  = t1_ff.vec;
      c2_in.cs   = t1_ff.cs;
      c2_in.sn   = t1_ff.sn;
      c2_in.zero = zero1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff  <= c2_in;
         an2_ff <= an2_in;
      end
   end

   // squares of the scaled components
   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff  <= c2_ff;
         an3_ff <= an2_ff;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= (2*NORM_W)'($signed(an2_ff[i]) * $signed(an2_ff[i]));
         end
      end
   end

   // sum of squares
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.c  <= c3_ff;
         out_ff.an <= an3_ff;
         out_ff.ss <= WIDE_W'(sq_ff[0]) + WIDE_W'(sq_ff[1]) + WIDE_W'(sq_ff[2]);
      end
   end

   assign out_valid = valid_ff[4];
   assign out_item  = out_ff;

endmodule

@@ rtl/core/vecrot_isqrt.sv @@
// ----------------------------------------------------------------------------
// vecrot_isqrt
// Pipelined integer square root of the sum of squares, one result bit per
// stage, restoring digit by digit from the top pair of bits.
// ----------------------------------------------------------------------------
module vecrot_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  vecrot_pkg::norm_item_type  in_item,
   output logic                       out_valid,
   output vecrot_pkg::root_item_type  out_item
);
   import vecrot_pkg::*;

   logic [SQRT_STEPS-1:0] valid_ff;
   logic [WIDE_W-1:0]     n_ff    [SQRT_STEPS];
   logic [WIDE_W-1:0]     root_ff [SQRT_STEPS];
   carry_type             c_ff    [SQRT_STEPS];
   norm_type [2:0]        an_ff   [SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[SQRT_STEPS-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [WIDE_W-1:0] n_src;
      logic [WIDE_W-1:0] r_src;
      logic [WIDE_W-1:0] bit_val;
      logic [WIDE_W-1:0] cand;
      logic [WIDE_W-1:0] n_in;
      logic [WIDE_W-1:0] root_in;
      carry_type         c_src;
      norm_type [2:0]    an_src;

      if (k == 0) begin : g_first
         assign n_src  = in_item.ss;
         assign r_src  = '0;
         assign c_src  = in_item.c;
         assign an_src = in_item.an;
      end else begin : g_next
         assign n_src  = n_ff[k-1];
         assign r_src  = root_ff[k-1];
         assign c_src  = c_ff[k-1];
         assign an_src = an_ff[k-1];
      end

      assign bit_val = WIDE_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      assign cand    = r_src + bit_val;

      // one root digit
      always_comb begin
         if (n_src >= cand) begin
            n_in    = n_src - cand;
            root_in = (r_src >> 1) + bit_val;
         end else begin
            n_in    = n_src;
            root_in = r_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]    <= n_in;
            root_ff[k] <= root_in;
            c_ff[k]    <= c_src;
            an_ff[k]   <= an_src;
         end
      end
   end

   assign out_valid    = valid_ff[SQRT_STEPS-1];
   assign out_item.c   = c_ff[SQRT_STEPS-1];
   assign out_item.an  = an_ff[SQRT_STEPS-1];
   assign out_item.len = root_ff[SQRT_STEPS-1][LEN_W-1:0];

endmodule

@@ rtl/core/vecrot_udiv.sv @@
// ----------------------------------------------------------------------------
// vecrot_udiv
// Three-lane pipelined restoring divider forming the unit axis as a rounded
// quotient of the scaled axis over its length, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vecrot_udiv (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  vecrot_pkg::root_item_type  in_item,
   output logic                       out_valid,
   output vecrot_pkg::unit_item_type  out_item
);
   import vecrot_pkg::*;

   logic [QUO_W+1:0]  valid_ff;
   logic [WIDE_W-1:0] rem_ff [QUO_W+1][3];
   logic [QUO_W-1:0]  q_ff   [QUO_W+1][3];
   logic [2:0]        neg_ff [QUO_W+1];
   logic [LEN_W-1:0]  len_ff [QUO_W+1];
   carry_type         c_ff   [QUO_W+1];
   unit_item_type     out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QUO_W:0], in_valid};
      end
   end

   // dividend: |an| * 2^30 plus half the divisor for rounding
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= ((in_item.an[i][NORM_W-1] ? -WIDE_W'($signed(in_item.an[i]))
                                                      : WIDE_W'($signed(in_item.an[i])))
                             << UNIT_BITS) + WIDE_W'(in_item.len >> 1);
            q_ff[0][i]   <= '0;
            neg_ff[0][i] <= in_item.an[i][NORM_W-1];
         end
         len_ff[0] <= in_item.len;
         c_ff[0]   <= in_item.c;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      logic [WIDE_W-1:0] dv;

      assign dv = WIDE_W'(len_ff[j]) << (QUO_W - 1 - j);

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               if (rem_ff[j][i] >= dv) begin
                  rem_ff[j+1][i] <= rem_ff[j][i] - dv;
                  q_ff[j+1][i]   <= q_ff[j][i] | (QUO_W'(1) << (QUO_W - 1 - j));
               end else begin
                  rem_ff[j+1][i] <= rem_ff[j][i];
                  q_ff[j+1][i]   <= q_ff[j][i];
               end
            end
            neg_ff[j+1] <= neg_ff[j];
            len_ff[j+1] <= len_ff[j];
            c_ff[j+1]   <= c_ff[j];
         end
      end
   end

   // restore the sign
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.c <= c_ff[QUO_W];
         for (int i = 0; i < 3; i++) begin
            out_ff.u[i] <= neg_ff[QUO_W][i] ? -$signed(q_ff[QUO_W][i])
                                            : $signed(q_ff[QUO_W][i]);
         end
      end
   end

   assign out_valid = valid_ff[QUO_W+1];
   assign out_item  = out_ff;

endmodule

@@ rtl/core/vecrot_combine.sv @@
// ----------------------------------------------------------------------------
// vecrot_combine
// Rodrigues back end: projection onto the unit axis, rejection, cross
// product, cos / sin weighting, rounding and saturation of the result.
// ----------------------------------------------------------------------------
module vecrot_combine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  vecrot_pkg::unit_item_type  in_item,
   output logic                       out_valid,
   output vecrot_pkg::result_type     out_item
);
   import vecrot_pkg::*;

   localparam int PROD_W = 2 * COMP_W;
   localparam int DOT_W  = PROD_W + 2;
   localparam int PJ_W   = COMP_W + 4;
   localparam int PQ_W   = PJ_W + COMP_W;
   localparam int WS_W   = PJ_W + TRIG_W + 1;
   localparam int T_W    = WS_W - TRIG_BITS;
   localparam int S_W    = T_W + 1;
   localparam logic signed [S_W-1:0] SAT_HI = (S_W'(1) <<< (COMP_W - 1)) - S_W'(1);
   localparam logic signed [S_W-1:0] SAT_LO = -(S_W'(1) <<< (COMP_W - 1));

   logic [6:0] valid_ff;

   // stage 0: dot and cross partial products
   carry_type                 c0_ff;
   comp_type [2:0]            u0_ff;
   logic signed [PROD_W-1:0]  pvu_ff [3];
   logic signed [PROD_W-1:0]  cpa_ff [3];
   logic signed [PROD_W-1:0]  cpb_ff [3];
   // stage 1: rounded dot product and cross product
   carry_type                 c1_ff;
   comp_type [2:0]            u1_ff;
   logic signed [PJ_W-1:0]    dq_ff;
   logic signed [PJ_W-1:0]    cr1_ff [3];
   logic signed [PJ_W-1:0]    dq_in;
   logic signed [PJ_W-1:0]    cr1_in [3];
   // stage 2: projection products
   carry_type                 c2_ff;
   logic signed [PJ_W-1:0]    cr2_ff [3];
   logic signed [PQ_W-1:0]    pq_ff  [3];
   // stage 3: projection and rejection
   carry_type                 c3_ff;
   logic signed [PJ_W-1:0]    cr3_ff [3];
   logic signed [PJ_W-1:0]    p3_ff  [3];
   logic signed [PJ_W-1:0]    r3_ff  [3];
   logic signed [PJ_W-1:0]    p3_in  [3];
   logic signed [PJ_W-1:0]    r3_in  [3];
   // stage 4: cos and sin weighting
   carry_type                 c4_ff;
   logic                      rz4_ff;
   logic signed [PJ_W-1:0]    p4_ff  [3];
   logic signed [PQ_W-1:0]    m1_ff  [3];
   logic signed [PQ_W-1:0]    m2_ff  [3];
   // stage 5: rounded weighted sum
   carry_type                 c5_ff;
   logic                      rz5_ff;
   logic signed [PJ_W-1:0]    p5_ff  [3];
   logic signed [T_W-1:0]     t5_ff  [3];
   logic signed [T_W-1:0]     t5_in  [3];
   // stage 6: result
   result_type                out_ff;
   result_type                out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   // dot and cross products
   always_ff @(posedge clock) begin
      if (en) begin
         c0_ff <= in_item.c;
         u0_ff <= in_item.u;
         for (int i = 0; i < 3; i++) begin
            pvu_ff[i] <= $signed(in_item.c.vec[i]) * $signed(in_item.u[i]);
         end
         cpa_ff[0] <= $signed(in_item.u[1]) * $signed(in_item.c.vec[2]);
         cpb_ff[0] <= $signed(in_item.u[2]) * $signed(in_item.c.vec[1]);
         cpa_ff[1] <= $signed(in_item.u[2]) * $signed(in_item.c.vec[0]);
         cpb_ff[1] <= $signed(in_item.u[0]) * $signed(in_item.c.vec[2]);
         cpa_ff[2] <= $signed(in_item.u[0]) * $signed(in_item.c.vec[1]);
         cpb_ff[2] <= $signed(in_item.u[1]) * $signed(in_item.c.vec[0]);
      end
   end

   // round dot product and cross product back to the component format
   always_comb begin
      logic signed [DOT_W-1:0]  dsum;
      logic signed [PROD_W:0]   cd;
      dsum  = DOT_W'(pvu_ff[0]) + DOT_W'(pvu_ff[1]) + DOT_W'(pvu_ff[2])
              + (DOT_W'(1) << (UNIT_BITS - 1));
      dq_in = PJ_W'($signed(dsum[DOT_W-1:UNIT_BITS]));
      for (int i = 0; i < 3; i++) begin
         cd        = (PROD_W+1)'(cpa_ff[i]) - (PROD_W+1)'(cpb_ff[i])
                     + ((PROD_W+1)'(1) << (UNIT_BITS - 1));
         cr1_in[i] = PJ_W'($signed(cd[PROD_W:UNIT_BITS]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff  <= c0_ff;
         u1_ff  <= u0_ff;
         dq_ff  <= dq_in;
         cr1_ff <= cr1_in;
      end
   end

   // projection along the unit axis
   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff  <= c1_ff;
         cr2_ff <= cr1_ff;
         for (int i = 0; i < 3; i++) begin
            pq_ff[i] <= dq_ff * $signed(u1_ff[i]);
         end
      end
   end

   // round the projection, rejection is what is left
   always_comb begin
      logic signed [PQ_W-1:0] pr;
      for (int i = 0; i < 3; i++) begin
         pr       = pq_ff[i] + (PQ_W'(1) << (UNIT_BITS - 1));
         p3_in[i] = PJ_W'($signed(pr[PQ_W-1:UNIT_BITS]));
         r3_in[i] = PJ_W'($signed(c2_ff.vec[i])) - p3_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff  <= c2_ff;
         cr3_ff <= cr2_ff;
         p3_ff  <= p3_in;
         r3_ff  <= r3_in;
      end
   end

   // weight rejection by cos and cross product by sin
   always_ff @(posedge clock) begin
      if (en) begin
         c4_ff  <= c3_ff;
         p4_ff  <= p3_ff;
         rz4_ff <= (r3_ff[0] == '0) && (r3_ff[1] == '0) && (r3_ff[2] == '0);
         for (int i = 0; i < 3; i++) begin
            m1_ff[i] <= r3_ff[i] * c3_ff.cs;
            m2_ff[i] <= cr3_ff[i] * c3_ff.sn;
         end
      end
   end

   // round the weighted sum to the component format
   always_comb begin
      logic signed [WS_W-1:0] ws;
      for (int i = 0; i < 3; i++) begin
         ws       = WS_W'(m1_ff[i]) + WS_W'(m2_ff[i]) + (WS_W'(1) << (TRIG_BITS - 1));
         t5_in[i] = $signed(ws[WS_W-1:TRIG_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c5_ff  <= c4_ff;
         rz5_ff <= rz4_ff;
         p5_ff  <= p4_ff;
         t5_ff  <= t5_in;
      end
   end

   // add back the projection, saturate, pick the special cases
   always_comb begin
      logic signed [S_W-1:0] s;
      out_in.success = !c5_ff.zero;
      for (int i = 0; i < 3; i++) begin
         s = S_W'(p5_ff[i]) + S_W'(t5_ff[i]);
         if (c5_ff.zero) begin
            out_in.rot[i] = '0;
         end else if (rz5_ff) begin
            out_in.rot[i] = c5_ff.vec[i];
         end else if (s > SAT_HI) begin
            out_in.rot[i] = COMP_W'(SAT_HI);
         end else if (s < SAT_LO) begin
            out_in.rot[i] = COMP_W'(SAT_LO);
         end else begin
            out_in.rot[i] = COMP_W'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff[6];
   assign out_item  = out_ff;

endmodule

@@ rtl/core/vector_axis_rotation_core.sv @@
// ----------------------------------------------------------------------------
// vector_axis_rotation_core
// Rotates a Q16.16 vector about an arbitrary axis by a binary angle.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted per cycle while the result side does
// not stall. Items pass 18 rotator stages, 5 axis scaling stages, 32 square
// root stages, 34 divider stages and 7 combining stages; the square root and
// divider give one bit per stage. A stall on the result side freezes the whole
// pipeline in place and shows on req_stall in the same cycle; nothing is lost
// or repeated. A zero axis gives zero components with success low.
// ----------------------------------------------------------------------------
module vector_axis_rotation_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  vecrot_pkg::comp_type             req_vec_x,
   input  vecrot_pkg::comp_type             req_vec_y,
   input  vecrot_pkg::comp_type             req_vec_z,
   input  vecrot_pkg::comp_type             req_axis_x,
   input  vecrot_pkg::comp_type             req_axis_y,
   input  vecrot_pkg::comp_type             req_axis_z,
   input  logic [vecrot_pkg::ANGLE_W-1:0]   req_turn_angle,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output vecrot_pkg::comp_type             rsp_rot_x,
   output vecrot_pkg::comp_type             rsp_rot_y,
   output vecrot_pkg::comp_type             rsp_rot_z,
   output logic                             rsp_success
);
   import vecrot_pkg::*;

   logic          en;
   item_type      in_item;
   logic          trig_valid;
   trig_item_type trig_item;
   logic          norm_valid;
   norm_item_type norm_item;
   logic          root_valid;
   root_item_type root_item;
   logic          unit_valid;
   unit_item_type unit_item;
   result_type    result;

   // the pipeline moves unless a finished item is held at the output
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   assign in_item.vec[0]  = req_vec_x;
   assign in_item.vec[1]  = req_vec_y;
   assign in_item.vec[2]  = req_vec_z;
   assign in_item.axis[0] = req_axis_x;
   assign in_item.axis[1] = req_axis_y;
   assign in_item.axis[2] = req_axis_z;
   assign in_item.angle   = req_turn_angle;

   vecrot_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_item   (in_item),
      .out_valid (trig_valid),
      .out_item  (trig_item)
   );

   vecrot_axis_prep u_axis_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (trig_valid),
      .in_item   (trig_item),
      .out_valid (norm_valid),
      .out_item  (norm_item)
   );

   vecrot_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (norm_valid),
      .in_item   (norm_item),
      .out_valid (root_valid),
      .out_item  (root_item)
   );

   vecrot_udiv u_udiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (root_valid),
      .in_item   (root_item),
      .out_valid (unit_valid),
      .out_item  (unit_item)
   );

   vecrot_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (unit_valid),
      .in_item   (unit_item),
      .out_valid (rsp_valid),
      .out_item  (result)
   );

   assign rsp_rot_x   = result.rot[0];
   assign rsp_rot_y   = result.rot[1];
   assign rsp_rot_z   = result.rot[2];
   assign rsp_success = result.success;

endmodule

@@ rtl/core/vecrot_checker.sv @@
// ----------------------------------------------------------------------------
// vecrot_checker
// Port-level checks on the rotation core, bound to the top level.
// ----------------------------------------------------------------------------
module vecrot_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input vecrot_pkg::comp_type rsp_rot_x,
   input vecrot_pkg::comp_type rsp_rot_y,
   input vecrot_pkg::comp_type rsp_rot_z,
   input logic                 rsp_success
);

   // a held result item keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_rot_x)
         && $stable(rsp_rot_y) && $stable(rsp_rot_z) && $stable(rsp_success)))
      else $error("result item changed while stalled");

   // the request side stalls only behind a held result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   // a failed rotation carries zero components
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |-> (rsp_rot_x == '0 && rsp_rot_y == '0
         && rsp_rot_z == '0))
      else $error("failed rotation with nonzero components");

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind vector_axis_rotation_core vecrot_checker u_vecrot_checker (.*);

@@ tb/tb_vector_axis_rotation_core.sv @@
// ----------------------------------------------------------------------------
// tb_vector_axis_rotation_core
// Self-checking bench for the axis-angle vector rotation pipeline. Each
// accepted item is run through a bit-exact fixed-point rotation in the bench
// and the result is queued. Results are compared in order, field by field.
// Stimulus covers directed corners, random items under varying idle patterns
// on both sides, and a long result-side hold-off that backs the pipe up.
// ----------------------------------------------------------------------------
module tb_vector_axis_rotation_core;
   import vecrot_pkg::*;

   localparam int LATENCY    = 96;
   localparam int RAND_ITEMS = 800;

   typedef struct {
      comp_type x, y, z;
      logic     success;
   } rotation_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   comp_type req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   comp_type req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic [ANGLE_W-1:0] req_turn_angle = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   comp_type rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic     rsp_success;

   rotation_type expected_rotations[$];
   int  mismatch_count = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_cycles = 0;

   vector_axis_rotation_core DUT (.*);

   // clock
   always #5 clock = ~clock;

   // fixed-point rotation helpers
   function automatic longint floor_shr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint round_shr(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint unsigned abs_mag(input longint v);
      return v < 0 ? longint'(-(v + 1)) + 1 : v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic longint rounded_div(input longint num, input longint unsigned den);
      longint unsigned q;
      if (den == 0) return 0;
      q = (abs_mag(num) + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic rotation_type rotate_vector(input comp_type vx, vy, vz, ax, ay, az,
                                                  input logic [ANGLE_W-1:0] ang);
      rotation_type res;
      longint v[3], a[3], an[3], u[3], p[3], r[3], c[3], o[3];
      longint d, dq, x, y, z, dx, dy, cs, sn, hi, lo;
      longint unsigned m, ss, len;
      logic [31:0] turn;
      int bits, shift;
      v[0] = vx; v[1] = vy; v[2] = vz;
      a[0] = ax; a[1] = ay; a[2] = az;
      m = 0;
      for (int i = 0; i < 3; i++)
         if (abs_mag(a[i]) > m) m = abs_mag(a[i]);
      // zero axis fails
      if (m == 0) begin
         res.x = '0; res.y = '0; res.z = '0; res.success = 1'b0;
         return res;
      end
      bits = 0;
      while (bits < 64 && (m >> bits) != 0) bits++;
      shift = bits - UNIT_BITS;
      ss = 0;
      for (int i = 0; i < 3; i++) begin
         an[i] = shift > 0 ? floor_shr(a[i], shift) : a[i] <<< (-shift);
         ss += longint'(an[i] * an[i]);
      end
      len = int_sqrt(ss);
      for (int i = 0; i < 3; i++) u[i] = rounded_div(an[i] <<< UNIT_BITS, len);
      d = v[0] * u[0] + v[1] * u[1] + v[2] * u[2];
      dq = round_shr(d, UNIT_BITS);
      for (int i = 0; i < 3; i++) begin
         p[i] = round_shr(dq * u[i], UNIT_BITS);
         r[i] = v[i] - p[i];
      end
      if (r[0] == 0 && r[1] == 0 && r[2] == 0) begin
         // vector along the axis comes back as it was
         for (int i = 0; i < 3; i++) o[i] = v[i];
      end else begin
         c[0] = round_shr(u[1] * v[2] - u[2] * v[1], UNIT_BITS);
         c[1] = round_shr(u[2] * v[0] - u[0] * v[2], UNIT_BITS);
         c[2] = round_shr(u[0] * v[1] - u[1] * v[0], UNIT_BITS);
         // cordic on the residual angle, then the quadrant
         turn = {ang, {(32 - ANGLE_W){1'b0}}};
         z = longint'(turn[29:0]);
         x = longint'(CORDIC_GAIN >> (32 - TRIG_BITS));
         y = 0;
         for (int i = 0; i < TRIG_ITER; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(atan_turn(i));
            end else begin
               x += dx; y -= dy; z += longint'(atan_turn(i));
            end
         end
         case (turn[31:30])
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
         endcase
         hi = (64'sd1 <<< (COMP_W - 1)) - 1;
         lo = -hi - 1;
         for (int i = 0; i < 3; i++) begin
            o[i] = p[i] + round_shr(r[i] * cs + c[i] * sn, TRIG_BITS);
            o[i] = o[i] > hi ? hi : (o[i] < lo ? lo : o[i]);
         end
      end
      res.x = o[0][COMP_W-1:0];
      res.y = o[1][COMP_W-1:0];
      res.z = o[2][COMP_W-1:0];
      res.success = 1'b1;
      return res;
   endfunction

   // offer one item, wait for acceptance, then maybe idle
   task automatic send_item(input comp_type vx, vy, vz, ax, ay, az,
                            input logic [ANGLE_W-1:0] ang);
      req_vec_x <= vx; req_vec_y <= vy; req_vec_z <= vz;
      req_axis_x <= ax; req_axis_y <= ay; req_axis_z <= az;
      req_turn_angle <= ang;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_rotations.push_back(rotate_vector(vx, vy, vz, ax, ay, az, ang));
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // result checking
   always @(posedge clock) begin
      rotation_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_rotations.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: %0d %0d %0d success %0b",
                        rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_success);
         end else begin
            exp_r = expected_rotations.pop_front();
            if (rsp_rot_x !== exp_r.x || rsp_rot_y !== exp_r.y ||
                rsp_rot_z !== exp_r.z || rsp_success !== exp_r.success) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %0d %0d %0d s%0b, got %0d %0d %0d s%0b",
                           exp_r.x, exp_r.y, exp_r.z, exp_r.success,
                           rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_success);
            end
         end
      end
   end

   // result-side stalls, with a counted long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // random item with a mix of shapes
   task automatic send_random();
      comp_type vx, vy, vz, ax, ay, az;
      logic [ANGLE_W-1:0] ang;
      int kind, k;
      kind = $urandom_range(99);
      ang = $urandom;
      if (kind < 30) begin
         // full-range bit patterns
         vx = $urandom; vy = $urandom; vz = $urandom;
         ax = $urandom; ay = $urandom; az = $urandom;
      end else if (kind < 70) begin
         // moderate values, no saturation
         vx = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
         vy = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
         vz = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
         ax = $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh0001FFFF;
         ay = $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh0001FFFF;
         az = $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh0001FFFF;
      end else if (kind < 80) begin
         // vector along the axis
         ax = $signed($urandom_range(0, 2000)) - 1000;
         ay = $signed($urandom_range(0, 2000)) - 1000;
         az = $signed($urandom_range(0, 2000)) - 1000;
         k = $urandom_range(0, 200) - 100;
         vx = ax * k; vy = ay * k; vz = az * k;
      end else if (kind < 90) begin
         // axis along one coordinate
         vx = $urandom; vy = $urandom; vz = $urandom;
         ax = '0; ay = '0; az = '0;
         k = $urandom_range(1, 32'h7FFFFFFF);
         case ($urandom_range(2))
            0: ax = $urandom_range(1) ? k : -k;
            1: ay = $urandom_range(1) ? k : -k;
            default: az = $urandom_range(1) ? k : -k;
         endcase
      end else if (kind < 95) begin
         // zero axis
         vx = $urandom; vy = $urandom; vz = $urandom;
         ax = '0; ay = '0; az = '0;
      end else begin
         // tiny axis, small vector
         vx = $signed($urandom_range(0, 64)) - 32;
         vy = $signed($urandom_range(0, 64)) - 32;
         vz = $signed($urandom_range(0, 64)) - 32;
         ax = $signed($urandom_range(0, 4)) - 2;
         ay = $signed($urandom_range(0, 4)) - 2;
         az = $signed($urandom_range(0, 4)) - 2;
      end
      send_item(vx, vy, vz, ax, ay, az, ang);
   endtask

   task automatic test_directed();
      localparam comp_type MAXC = 32'sh7FFFFFFF;
      localparam comp_type MINC = 32'sh80000000;
      localparam comp_type ONE  = 32'sh00010000;
      // zero axis, with and without a vector
      send_item(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 16'h1234);
      send_item(0, 0, 0, 0, 0, 0, 16'h0000);
      // zero vector
      send_item(0, 0, 0, ONE, 0, 0, 16'h4000);
      // vector parallel and antiparallel to the axis
      send_item(3 * ONE, 0, 0, ONE, 0, 0, 16'h2000);
      send_item(0, 0, -5 * ONE, 0, 0, 7 * ONE, 16'h9000);
      // quarter turns about z
      send_item(ONE, 0, 0, 0, 0, ONE, 16'h0000);
      send_item(ONE, 0, 0, 0, 0, ONE, 16'h4000);
      send_item(ONE, 0, 0, 0, 0, ONE, 16'h8000);
      send_item(ONE, 0, 0, 0, 0, ONE, 16'hC000);
      send_item(ONE, 0, 0, 0, 0, ONE, 16'hFFFF);
      // extreme components, saturation
      send_item(MAXC, MAXC, MAXC, MAXC, MINC, 0, 16'h3000);
      send_item(MINC, MINC, MINC, MINC, MINC, MINC, 16'h8001);
      send_item(MAXC, MINC, MAXC, 0, MINC, MAXC, 16'h5555);
      send_item(MINC, 0, MAXC, 1, 0, 0, 16'hAAAA);
      send_item(-1, -1, -1, -1, 1, -1, 16'h7FFF);
      send_item(MAXC, 0, 0, 0, 1, 0, 16'h6000);
      send_item(ONE, ONE, ONE, 1, 1, 1, 16'h0001);
   endtask

   task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      repeat (count) send_random();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 300;
      repeat (200) send_random();
   endtask

   // stimulus
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(RAND_ITEMS / 3, 8, 72);
      test_random(RAND_ITEMS / 3, 72, 8);
      test_random(RAND_ITEMS / 3, 0, 0);
      test_backpressure();
      req_valid <= 1'b0;
      recv_idle_pct = 20;
      while (expected_rotations.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("covered %0d items: directed corners, random shapes, idle mixes, long hold-off",
               items_sent);
      $display("%0d results checked, %0d mismatches", results_seen, mismatch_count);
      if (mismatch_count == 0 && expected_rotations.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("timeout with %0d results outstanding", expected_rotations.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
